>>> rtl/gfli_pkg.sv
// Shared types and constants for the gap-filling linear interpolator.
package gfli_pkg;

    localparam int MAX_LEN     = 64;
    localparam int VAL_W       = 15;
    localparam int GAP_W       = $clog2(MAX_LEN);
    localparam int CNT_W       = $clog2(MAX_LEN + 1);
    localparam int DEN_W       = GAP_W + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_CW      = $clog2(VAL_W + 1);

    localparam logic [VAL_W-1:0] EMPTY_FILL_RESET = VAL_W'(8192);

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } gfli_in_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last_out;
    } gfli_out_t;

    // One burst of results: gap filler points, then the closing point.
    typedef struct packed {
        logic             interp;
        logic [VAL_W-1:0] base;
        logic [VAL_W-1:0] target;
        logic [GAP_W-1:0] gap;
        logic             fin;
    } gfli_job_t;

endpackage

>>> rtl/gfli_fifo.sv
// Small register queue of jobs between the front and back parts.
module gfli_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  gfli_pkg::gfli_job_t wr_job,
    input  logic               pop,
    output gfli_pkg::gfli_job_t rd_job,
    output logic               full,
    output logic               not_empty
);
    import gfli_pkg::*;

    gfli_job_t           entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;

    assign full      = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_job    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

>>> rtl/gfli_front.sv
// Front part: takes input transactions, tracks the sequence and queues result bursts.
module gfli_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  gfli_pkg::gfli_in_t          in_data,
    input  logic                        cfg_wr_en,
    input  logic [gfli_pkg::VAL_W-1:0]  cfg_wr_data,
    input  logic                        q_full,
    output logic                        push,
    output gfli_pkg::gfli_job_t         job
);
    import gfli_pkg::*;

    logic [VAL_W-1:0] empty_fill_reg;
    logic [VAL_W-1:0] prev_known_reg, prev_known_next;
    logic             have_known_reg, have_known_next;
    logic [GAP_W-1:0] gap_len_reg, gap_len_next;
    logic [CNT_W-1:0] item_count_reg, item_count_next;

    logic             accept;
    logic             missing;
    logic [VAL_W-1:0] v;
    logic [CNT_W-1:0] cnt;
    logic             seq_end;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign missing  = in_data.sample[15];
    assign v        = in_data.sample[VAL_W-1:0];
    assign cnt      = item_count_reg + 1'b1;
    assign seq_end  = in_data.last || (cnt >= CNT_W'(MAX_LEN));

    // A missing point that does not end the sequence only grows the gap.
    assign push = accept && (!missing || seq_end);

    always_comb
    begin
        job.interp = !missing && have_known_reg;
        job.base   = prev_known_reg;
        job.gap    = gap_len_reg;
        job.fin    = missing ? 1'b1 : seq_end;
        if (!missing)
        begin
            job.target = v;
        end
        else
        begin
            job.target = have_known_reg ? prev_known_reg : empty_fill_reg;
        end
    end

    always_comb
    begin
        prev_known_next = prev_known_reg;
        have_known_next = have_known_reg;
        gap_len_next    = gap_len_reg;
        item_count_next = item_count_reg;
        if (accept)
        begin
            if (!missing)
            begin
                prev_known_next = v;
                have_known_next = 1'b1;
                gap_len_next    = '0;
            end
            else if (!seq_end)
            begin
                gap_len_next = gap_len_reg + 1'b1;
            end
            if (seq_end)
            begin
                prev_known_next = '0;
                have_known_next = 1'b0;
                gap_len_next    = '0;
                item_count_next = '0;
            end
            else
            begin
                item_count_next = cnt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_fill_reg <= EMPTY_FILL_RESET;
            prev_known_reg <= '0;
            have_known_reg <= 1'b0;
            gap_len_reg    <= '0;
            item_count_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                empty_fill_reg <= cfg_wr_data;
            end
            prev_known_reg <= prev_known_next;
            have_known_reg <= have_known_next;
            gap_len_reg    <= gap_len_next;
            item_count_reg <= item_count_next;
        end
    end

endmodule

>>> rtl/gfli_div.sv
// Radix-2 restoring divider: step magnitude over gap length, one quotient bit per cycle.
module gfli_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [gfli_pkg::VAL_W-1:0]  dividend,
    input  logic [gfli_pkg::DEN_W-1:0]  divisor,
    output logic                        done,
    output logic [gfli_pkg::VAL_W-1:0]  quotient,
    output logic [gfli_pkg::DEN_W-1:0]  remainder
);
    import gfli_pkg::*;

    logic [DIV_CW-1:0] count_reg, count_next;
    logic              done_reg, done_next;
    logic [VAL_W-1:0]  quo_reg, quo_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    trial_diff;

    assign trial      = {rem_reg, quo_reg[VAL_W-1]};
    assign trial_diff = trial - {1'b0, den_reg};

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    always_comb
    begin
        count_next = count_reg;
        done_next  = 1'b0;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        if (start)
        begin
            count_next = DIV_CW'(VAL_W);
            quo_next   = dividend;
            rem_next   = '0;
            den_next   = divisor;
        end
        else if (count_reg != '0)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial_diff[DEN_W-1:0];
                quo_next = {quo_reg[VAL_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[VAL_W-2:0], 1'b0};
            end
            count_next = count_reg - 1'b1;
            done_next  = (count_reg == DIV_CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

endmodule

>>> rtl/gfli_back.sv
// Back part: turns queued bursts into result transactions, interpolating gaps.
module gfli_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_not_empty,
    input  gfli_pkg::gfli_job_t q_job,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output gfli_pkg::gfli_out_t out_data
);
    import gfli_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    gfli_job_t        job_reg, job_next;
    logic             neg_reg, neg_next;
    logic [GAP_W-1:0] k_reg, k_next;
    logic [VAL_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] r_reg, r_next;
    logic [VAL_W-1:0] qa_reg, qa_next;
    logic [DEN_W-1:0] ra_reg, ra_next;
    logic             out_valid_reg, out_valid_next;
    gfli_out_t        out_reg, out_next;

    logic             load;
    logic signed [VAL_W:0] head_diff;
    logic [VAL_W-1:0] head_mag;
    logic             div_start;
    logic             div_done;
    logic [VAL_W-1:0] div_quo;
    logic [DEN_W-1:0] div_rem;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] head_den;
    logic [DEN_W:0]   r_sum;
    logic             r_wrap;
    logic [VAL_W-1:0] q_step;
    logic [DEN_W-1:0] r_step;
    logic [VAL_W-1:0] interp_val;

    assign load = !out_valid_reg || !out_stall;

    assign head_diff = $signed({1'b0, q_job.target}) - $signed({1'b0, q_job.base});
    assign head_mag  = head_diff[VAL_W] ? VAL_W'(-head_diff) : head_diff[VAL_W-1:0];
    assign head_den  = {1'b0, q_job.gap} + 1'b1;
    assign den       = {1'b0, job_reg.gap} + 1'b1;

    // |diff| = qa*den + ra, so k*|diff|/den advances by qa, plus one on remainder wrap.
    assign r_sum      = {1'b0, r_reg} + {1'b0, ra_reg};
    assign r_wrap     = (r_sum >= {1'b0, den});
    assign r_step     = r_wrap ? DEN_W'(r_sum - {1'b0, den}) : r_sum[DEN_W-1:0];
    assign q_step     = q_reg + qa_reg + VAL_W'(r_wrap);
    assign interp_val = neg_reg ? (job_reg.base - q_step) : (job_reg.base + q_step);

    assign div_start = (state_reg == S_IDLE) && q_not_empty
                       && q_job.interp && (q_job.gap != '0);
    assign q_pop     = (state_reg == S_IDLE) && q_not_empty;

    gfli_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (head_mag),
        .divisor   (head_den),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        neg_next       = neg_reg;
        k_next         = k_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        qa_next        = qa_reg;
        ra_next        = ra_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_not_empty)
                begin
                    job_next   = q_job;
                    neg_next   = head_diff[VAL_W];
                    k_next     = '0;
                    q_next     = '0;
                    r_next     = '0;
                    state_next = div_start ? S_DIV : S_EMIT;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    qa_next    = div_quo;
                    ra_next    = div_rem;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    if (k_reg != job_reg.gap)
                    begin
                        out_next.value    = job_reg.interp ? interp_val : job_reg.target;
                        out_next.last_out = 1'b0;
                        q_next            = q_step;
                        r_next            = r_step;
                        k_next            = k_reg + 1'b1;
                    end
                    else
                    begin
                        out_next.value    = job_reg.target;
                        out_next.last_out = job_reg.fin;
                        state_next        = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        neg_reg <= neg_next;
        k_reg   <= k_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        qa_reg  <= qa_next;
        ra_reg  <= ra_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

>>> rtl/gap_fill_linear_interpolator_core.sv
// Top level of the gap-filling linear interpolator.
// Fills missing Q1.14 samples (negative input) in a sequence: leading gaps copy the
// first known sample, inner gaps are interpolated with truncation toward zero,
// trailing gaps hold the last known sample, and an all-missing sequence yields
// empty_fill. A sequence ends on last or on its 64th item. The front takes one input
// transaction per cycle while the two-entry job queue has room; a missing sample that
// does not end the sequence takes no queue slot. The back takes a job from the queue,
// then, for an interpolated gap, runs the bit-serial divider (15 quotient bits) for the
// step, and then delivers gap+1 results at one per cycle while out_stall is low.
module gap_fill_linear_interpolator_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  gfli_pkg::gfli_in_t          in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output gfli_pkg::gfli_out_t         out_data,
    input  logic                        cfg_wr_en,
    input  logic [gfli_pkg::VAL_W-1:0]  cfg_wr_data
);
    import gfli_pkg::*;

    logic      push;
    logic      pop;
    logic      q_full;
    logic      q_not_empty;
    gfli_job_t wr_job;
    gfli_job_t rd_job;

    gfli_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_full      (q_full),
        .push        (push),
        .job         (wr_job)
    );

    gfli_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_job    (wr_job),
        .pop       (pop),
        .rd_job    (rd_job),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    gfli_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_job       (rd_job),
        .q_pop       (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule
